/* src/cfv_pkg.sv */
// Shared types, constants and the CRC-32 byte step for the frame validator.
// Depends on nothing; every other file in src imports it.
`timescale 1ns / 1ps
`default_nettype none

package cfv_pkg;

  // Fixed frame layout.
  localparam int HeaderBytes = 20;
  localparam int CrcSpan     = 16;
  localparam int LenSumW     = 17;

  // Reflected CRC-32 constants.
  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

  // Verdict codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_BAD_HDR  = 3'd2,
    ST_LEN_OVER = 3'd3,
    ST_CRC_BAD  = 3'd4
  } status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MAGIC   = 2'd0,
    REG_VERSION = 2'd1,
    REG_MAX_LEN = 2'd2
  } cfg_reg_e;

  // One input word as held in the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_word_t;

  // One verdict word.
  typedef struct packed {
    status_e     status;
    logic [7:0]  msg_type;
    logic [15:0] header_flags;
    logic [7:0]  channel_id;
    logic [7:0]  priority_level;
    logic [15:0] sequence_number;
    logic [31:0] deadline_value;
    logic [15:0] payload_length;
  } out_word_t;

  // Configuration values seen by the checker.
  typedef struct packed {
    logic [15:0] magic_word;
    logic [7:0]  version_byte;
    logic [12:0] len_limit;
  } cfg_t;

  // One byte through the reflected CRC-32, eight bit steps unrolled.
  function automatic logic [31:0] crc_step(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] crc;
    crc = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      crc = (crc >> 1) ^ (crc[0] ? CrcPoly : 32'd0);
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

/* src/cfv_in_stage.sv */
// Input register for the frame validator: holds one received word until
// the checker takes it. Depends on cfv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfv_in_stage (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  cfv_pkg::in_word_t in_word_i,
  input  wire               take_i,
  output logic              valid_o,
  output cfv_pkg::in_word_t word_o
);
  import cfv_pkg::*;

  logic     valid_q, valid_d;
  in_word_t word_q;
  logic     accept;

  // The register can refill in the cycle its word is taken.
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= in_word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

/* src/cfv_core.sv */
// Frame checker: header capture, running CRC-32, byte position and verdict
// decision, one byte per cycle unless the output is busy. Depends on cfv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfv_core #(
  parameter int PAYLOAD_LIMIT = 4096
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  cfv_pkg::cfg_t      cfg_i,
  input  wire                valid_i,
  input  cfv_pkg::in_word_t  word_i,
  input  wire                out_ready_i,
  output logic               take_o,
  output logic               res_valid_o,
  output cfv_pkg::out_word_t res_o
);
  import cfv_pkg::*;

  localparam int PosW = $clog2(HeaderBytes + PAYLOAD_LIMIT + 1);

  logic [PosW-1:0] pos_q, pos_d, pos_inc;
  logic [31:0]     crc_q, crc_d, crc_next;
  logic            verdict_q, verdict_d;
  logic [7:0]      hdr_q    [HeaderBytes];
  logic [7:0]      hdr_view [HeaderBytes];

  logic        crc_en, at_hdr_end, at_pay_end, have_header;
  logic        magic_bad, len_bad, crc_done, crc_ok, verdict_now, has_result;
  logic [15:0] len;
  logic [31:0] expected;
  status_e     status;

  // Header bytes with the current byte merged at its position.
  always_comb begin
    for (int i = 0; i < HeaderBytes; i++) begin
      hdr_view[i] = (pos_q == PosW'(i)) ? word_i.data_byte : hdr_q[i];
    end
  end

  // CRC covers header bytes 0-15 and the payload.
  assign crc_en   = (pos_q < PosW'(CrcSpan)) || (pos_q >= PosW'(HeaderBytes));
  assign crc_next = crc_en ? crc_step(crc_q, word_i.data_byte) : crc_q;
  assign pos_inc  = pos_q + PosW'(1);

  // Header checks.
  assign len       = {hdr_view[15], hdr_view[14]};
  assign expected  = {hdr_view[19], hdr_view[18], hdr_view[17], hdr_view[16]};
  assign magic_bad = ({hdr_view[1], hdr_view[0]} != cfg_i.magic_word) ||
                     (hdr_view[2] != cfg_i.version_byte);
  assign len_bad   = (len > {3'd0, cfg_i.len_limit}) || (len > 16'(PAYLOAD_LIMIT));

  // Decision points.
  assign at_hdr_end  = (pos_inc == PosW'(HeaderBytes));
  assign at_pay_end  = (pos_inc > PosW'(HeaderBytes)) &&
                       (LenSumW'(pos_inc) == LenSumW'(HeaderBytes) + LenSumW'(len));
  assign crc_done    = (at_hdr_end && !magic_bad && !len_bad && (len == 16'd0)) ||
                       at_pay_end;
  assign crc_ok      = (~crc_next == expected);
  assign verdict_now = (at_hdr_end && (magic_bad || len_bad)) || crc_done;
  assign have_header = (pos_inc >= PosW'(HeaderBytes));
  assign has_result  = !verdict_q && (verdict_now || word_i.end_of_buffer);

  always_comb begin
    if (at_hdr_end && magic_bad) begin
      status = ST_BAD_HDR;
    end else if (at_hdr_end && len_bad) begin
      status = ST_LEN_OVER;
    end else if (crc_done) begin
      status = crc_ok ? ST_OK : ST_CRC_BAD;
    end else begin
      status = ST_SHORT;
    end
  end

  // Result word; header fields read as zero when the header is incomplete.
  always_comb begin
    res_o        = '0;
    res_o.status = status;
    if (have_header) begin
      res_o.msg_type        = hdr_view[3];
      res_o.header_flags    = {hdr_view[5], hdr_view[4]};
      res_o.channel_id      = hdr_view[6];
      res_o.priority_level  = hdr_view[7];
      res_o.sequence_number = {hdr_view[9], hdr_view[8]};
      res_o.deadline_value  = {hdr_view[13], hdr_view[12], hdr_view[11], hdr_view[10]};
      res_o.payload_length  = len;
    end
  end

  assign take_o      = valid_i && (!has_result || out_ready_i);
  assign res_valid_o = valid_i && has_result;

  // Next frame state; the last byte of a buffer rearms the checker.
  always_comb begin
    pos_d     = pos_q;
    crc_d     = crc_q;
    verdict_d = verdict_q;
    if (take_o) begin
      if (word_i.end_of_buffer) begin
        pos_d     = '0;
        crc_d     = CrcInit;
        verdict_d = 1'b0;
      end else if (!verdict_q) begin
        pos_d     = pos_inc;
        crc_d     = crc_next;
        verdict_d = verdict_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      crc_q     <= CrcInit;
      verdict_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      verdict_q <= verdict_d;
    end
  end

  // Header capture; bytes past the header leave the view unchanged.
  always_ff @(posedge clk_i) begin
    if (take_o && !verdict_q) begin
      hdr_q <= hdr_view;
    end
  end

  // A buffer end always rearms the checker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && word_i.end_of_buffer) |=> (pos_q == '0) && !verdict_q && (crc_q == CrcInit))
    else $error("checker not rearmed after buffer end");

  // A verdict is only ever recorded once the header is complete.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict_q |-> (pos_q >= PosW'(HeaderBytes)))
    else $error("verdict recorded inside the header");

  // After a verdict, bytes do not emit, and only a buffer end moves the position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (verdict_q && take_o && !word_i.end_of_buffer) |=> $stable(pos_q) && verdict_q)
    else $error("position moved after verdict");

  // A byte that carries a result is never dropped when the output is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !out_ready_i) |-> !take_o)
    else $error("result byte taken while output is busy");

endmodule

`default_nettype wire

/* src/cfv_out_stage.sv */
// Output register for the frame validator: holds one verdict word until
// the receiver takes it. Depends on cfv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfv_out_stage (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                load_i,
  input  cfv_pkg::out_word_t word_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output cfv_pkg::out_word_t word_o
);
  import cfv_pkg::*;

  logic      valid_q;
  out_word_t word_q;
  logic      load;

  // Free when empty or when the held word leaves this cycle.
  assign ready_o = !valid_q || !out_stall_i;
  assign load    = load_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign word_o      = word_q;

endmodule

`default_nettype wire

/* src/crc32_frame_validator.sv */
// CRC-32 framed packet validator, top level: configuration registers and
// the input, checker and output stages. Depends on cfv_pkg and its submodules.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one byte of a received buffer per cycle, unless a verdict
// waits on a stalled output, and gives at most one verdict word per buffer:
// status plus the header fields. Every byte runs through a single registered
// pass (input register, one-byte CRC step and header checks, output register);
// a verdict leaves through the output register. The CRC step, eight unrolled
// bit updates of the reflected CRC-32, sets the cycle time.
// Write configuration only while no buffer is in flight.
module crc32_frame_validator #(
  parameter int PAYLOAD_LIMIT = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Configuration write port.
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [15:0] cfg_wdata_i,
  // Byte input channel.
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  data_byte_i,
  input  wire         end_of_buffer_i,
  // Verdict output channel.
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  msg_type_o,
  output logic [15:0] header_flags_o,
  output logic [7:0]  channel_id_o,
  output logic [7:0]  priority_level_o,
  output logic [15:0] sequence_number_o,
  output logic [31:0] deadline_value_o,
  output logic [15:0] payload_length_o
);
  import cfv_pkg::*;

  cfg_t      cfg_q;
  in_word_t  in_word, held_word;
  out_word_t res_word, out_word;
  logic      held_valid, take, res_valid, out_ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word   <= 16'd0;
      cfg_q.version_byte <= 8'd0;
      cfg_q.len_limit    <= 13'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAGIC:   cfg_q.magic_word   <= cfg_wdata_i;
        REG_VERSION: cfg_q.version_byte <= cfg_wdata_i[7:0];
        REG_MAX_LEN: cfg_q.len_limit    <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  assign in_word.data_byte     = data_byte_i;
  assign in_word.end_of_buffer = end_of_buffer_i;

  cfv_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word),
    .take_i     (take),
    .valid_o    (held_valid),
    .word_o     (held_word)
  );

  cfv_core #(
    .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (held_valid),
    .word_i      (held_word),
    .out_ready_i (out_ready),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res_word)
  );

  cfv_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .word_i      (res_word),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .word_o      (out_word)
  );

  assign status_o          = out_word.status;
  assign msg_type_o        = out_word.msg_type;
  assign header_flags_o    = out_word.header_flags;
  assign channel_id_o      = out_word.channel_id;
  assign priority_level_o  = out_word.priority_level;
  assign sequence_number_o = out_word.sequence_number;
  assign deadline_value_o  = out_word.deadline_value;
  assign payload_length_o  = out_word.payload_length;

endmodule

`default_nettype wire
